FILE: rtl/sharpen_3x3_convolution_assert.svh
// ---------------------------------------------------------------------------
// Sharpen 3x3 convolution assertion macros
// Concurrent assertion helpers. They expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SHARPEN_3X3_CONVOLUTION_ASSERT_SVH
`define SHARPEN_3X3_CONVOLUTION_ASSERT_SVH
`ifndef SYNTH
`define SHARP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sharpen assertion failed");
`define SHARP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sharpen assertion failed");
`else
`define SHARP_ASSERT(lbl, prop)
`define SHARP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: rtl/sharp_pkg.sv
// ---------------------------------------------------------------------------
// Sharpen 3x3 package
// Shared constants, payload types and register codes.
// ---------------------------------------------------------------------------
package sharp_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int PIX_W          = 8;
  localparam int COORD_W        = 10;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int WIN_N          = 3;
  localparam int FIFO_DEPTH     = 8;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [COORD_W-1:0] coord_t;

  // one column of the window: index 0 is the upper row
  typedef logic [WIN_N-1:0][PIX_W-1:0] col_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
    pix_t   pix;
    logic   last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

FILE: rtl/sharp_if.sv
// ---------------------------------------------------------------------------
// Sharpen 3x3 stream interfaces
// Valid/ready channels for input pixels and tagged result pixels.
// ---------------------------------------------------------------------------
interface sharp_in_if;
  import sharp_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sharp_out_if;
  import sharp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t out_row;
  coord_t out_col;
  pix_t   pixel_out;
  logic   last_in_run;

  modport source (output valid, output out_row, output out_col, output pixel_out,
                  output last_in_run, input ready);
  modport sink   (input valid, input out_row, input out_col, input pixel_out,
                  input last_in_run, output ready);
endinterface

FILE: rtl/sharp_win_cell.sv
// ---------------------------------------------------------------------------
// Sharpen window cell
// Holds one column of the 3x3 window and passes it on at every shift.
// ---------------------------------------------------------------------------
module sharp_win_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             shift,
  input  sharp_pkg::col_t  col_in,
  output sharp_pkg::col_t  col_out
);
  import sharp_pkg::*;

  col_t col_r;
  col_t col_nxt;

  // take the neighbor's column on shift, drop everything on clear
  always_comb begin
    col_nxt = col_r;
    if (clear) begin
      col_nxt = '0;
    end else if (shift) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_out = col_r;

endmodule

FILE: rtl/sharp_out_fifo.sv
// ---------------------------------------------------------------------------
// Sharpen result queue
// Small queue taking up to two results per cycle and handing out one while out_bus.ready is high.
// ---------------------------------------------------------------------------
`include "sharpen_3x3_convolution_assert.svh"

module sharp_out_fifo #(
  parameter int DEPTH = sharp_pkg::FIFO_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sharp_pkg::push_t [1:0]       push,
  output logic [$clog2(DEPTH+1)-1:0]   count,
  sharp_out_if.source                  out_bus
);
  import sharp_pkg::*;

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PW-1:0]   wr_ptr_p1, wr_ptr_p2;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);
  assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);
  assign pop       = out_bus.valid && out_bus.ready;

  // advance pointers and count; second slot is used only with the first
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push[1].valid) begin
      wr_ptr_nxt = wr_ptr_p2;
    end else if (push[0].valid) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push[0].valid) + CNT_W'(push[1].valid)
                 - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store results
  always_ff @(posedge clk) begin
    if (push[0].valid) begin
      mem_r[wr_ptr_r] <= push[0].data;
    end
    if (push[1].valid) begin
      mem_r[wr_ptr_p1] <= push[1].data;
    end
  end

  assign count               = count_r;
  assign out_bus.valid       = (count_r != '0);
  assign out_bus.out_row     = mem_r[rd_ptr_r].row;
  assign out_bus.out_col     = mem_r[rd_ptr_r].col;
  assign out_bus.pixel_out   = mem_r[rd_ptr_r].pix;
  assign out_bus.last_in_run = mem_r[rd_ptr_r].last;

  `SHARP_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH))
  `SHARP_ASSERT(a_no_overflow, 32'(count_r) + 32'(push[0].valid) + 32'(push[1].valid) <= DEPTH)
  `SHARP_ASSERT(a_push_packed, push[1].valid |-> push[0].valid)
  `SHARP_ASSERT_NEXT(a_pop_drains, pop && !push[0].valid, count_r == $past(count_r) - 1'b1)

endmodule

FILE: rtl/sharpen_3x3_convolution.sv
// An accepted pixel moves through stages s1 and s2; its results then enter the output queue.
// Throughput: one pixel per clock while in_bus.ready is high; a pixel with two results
// takes two queue entries, and in_bus.ready follows the queue's free space.
// Reset: synchronous active low; clears counters, window and queue, sets 640x480.
// The line store is not cleared; its contents reach the filter only after written in the frame.
// ---------------------------------------------------------------------------
// Sharpen 3x3 convolution top level
// Streams a raster frame through a two-row line store and a three-cell window,
// passes border pixels through and emits clamped sharpened interior pixels.
// ---------------------------------------------------------------------------
`include "sharpen_3x3_convolution_assert.svh"

module sharpen_3x3_convolution #(
  parameter int MAX_WIDTH  = sharp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sharp_pkg::DEF_MAX_HEIGHT,
  parameter int OUT_DEPTH  = sharp_pkg::FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sharp_in_if.sink                       in_bus,
  sharp_out_if.source                    out_bus,
  input  logic                           cfg_we,
  input  logic [sharp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sharp_pkg::CFG_W-1:0]    cfg_wdata
);
  import sharp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int CNT_W = $clog2(OUT_DEPTH+1);
  localparam int NW    = CNT_W + 2;
  localparam int SUM_W = PIX_W + 4;
  localparam int W_RST = (RESET_WIDTH  > MAX_WIDTH)  ? MAX_WIDTH  : RESET_WIDTH;
  localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [CW-1:0] w_last_r, col_r, col_nxt, s1_col_r, s2_col_r, w_cfg_last;
  logic [HW-1:0] h_last_r, row_r, row_nxt, s1_row_r, s2_row_r, h_cfg_last;
  logic          in_acc, border, filt;
  logic          s1_v_r, s1_border_r, s1_filt_r;
  logic          s2_v_r, s2_border_r, s2_filt_r;
  pix_t          s1_pix_r, s2_pix_r;
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  col_t          new_col, win0, win1, win2;
  logic signed [SUM_W-1:0] sum;
  pix_t          filt_pix;
  result_t       filt_res, bord_res;
  push_t [1:0]   push;
  logic [CNT_W-1:0] q_count;
  logic [NW-1:0] need;

  // admit a pixel only when the queue can absorb every result in flight
  assign need = NW'(q_count) + NW'({s1_v_r, 1'b0}) + NW'({s2_v_r, 1'b0}) + NW'(2);
  assign in_bus.ready = (need <= NW'(OUT_DEPTH));
  assign in_acc = in_bus.valid && in_bus.ready;

  // saturate written sizes to 1..MAX and store them as last index
  assign w_cfg_last = (cfg_wdata == '0) ? '0 :
                      (32'(cfg_wdata) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) :
                      CW'(cfg_wdata - 1'b1);
  assign h_cfg_last = (cfg_wdata == '0) ? '0 :
                      (32'(cfg_wdata) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT - 1) :
                      HW'(cfg_wdata - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(W_RST - 1);
      h_last_r <= HW'(H_RST - 1);
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        REG_FRAME_WIDTH:  w_last_r <= w_cfg_last;
        REG_FRAME_HEIGHT: h_last_r <= h_cfg_last;
        default: ;
      endcase
    end
  end

  // classify the arriving pixel
  assign border = (row_r == '0) || (col_r == '0) || (row_r == h_last_r) ||
                  (col_r == w_last_r);
  assign filt   = (row_r >= HW'(2)) && (col_r >= CW'(2));

  // advance raster position, wrap at end of row and frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_r == w_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r    <= in_bus.pixel_in;
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_border_r <= border;
      s1_filt_r   <= filt;
    end
    s2_pix_r    <= s1_pix_r;
    s2_col_r    <= s1_col_r;
    s2_row_r    <= s1_row_r;
    s2_border_r <= s1_border_r;
    s2_filt_r   <= s1_filt_r;
  end

  // line store: {upper, middle} per column, read on accept, rotated and written back in the cycle after
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= line_mem[col_r];
    end
    if (s1_v_r) begin
      line_mem[s1_col_r] <= {rd_r[PIX_W-1:0], s1_pix_r};
    end
  end

  assign new_col[0] = rd_r[2*PIX_W-1:PIX_W];
  assign new_col[1] = rd_r[PIX_W-1:0];
  assign new_col[2] = s1_pix_r;

  // window: three cells, the newest column enters at the right
  sharp_win_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .clear(cfg_we), .shift(s1_v_r),
    .col_in(new_col), .col_out(win2)
  );
  sharp_win_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .clear(cfg_we), .shift(s1_v_r),
    .col_in(win2), .col_out(win1)
  );
  sharp_win_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .clear(cfg_we), .shift(s1_v_r),
    .col_in(win1), .col_out(win0)
  );

  // 5*centre minus the upper, lower, left and right neighbors, clamped to the pixel range
  always_comb begin
    sum = $signed({2'b00, win1[1], 2'b00}) + $signed({4'b0000, win1[1]})
        - $signed({4'b0000, win1[0]}) - $signed({4'b0000, win1[2]})
        - $signed({4'b0000, win0[1]}) - $signed({4'b0000, win2[1]});
    if (sum[SUM_W-1]) begin
      filt_pix = '0;
    end else if (sum > $signed(SUM_W'(255))) begin
      filt_pix = '1;
    end else begin
      filt_pix = sum[PIX_W-1:0];
    end
  end

  // build results: filtered pixel first, border pixel after it
  always_comb begin
    filt_res.row  = COORD_W'(s2_row_r - 1'b1);
    filt_res.col  = COORD_W'(s2_col_r - 1'b1);
    filt_res.pix  = filt_pix;
    filt_res.last = !s2_border_r;
    bord_res.row  = COORD_W'(s2_row_r);
    bord_res.col  = COORD_W'(s2_col_r);
    bord_res.pix  = s2_pix_r;
    bord_res.last = 1'b1;
    push[0].valid = s2_v_r && (s2_filt_r || s2_border_r);
    push[0].data  = s2_filt_r ? filt_res : bord_res;
    push[1].valid = s2_v_r && s2_filt_r && s2_border_r;
    push[1].data  = bord_res;
  end

  sharp_out_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .count(q_count), .out_bus(out_bus)
  );

  `SHARP_ASSERT(a_pos_in_frame, (col_r <= w_last_r) && (row_r <= h_last_r))
  `SHARP_ASSERT(a_two_stage, ($past(in_acc, 2) && $past(rst_n, 2) && $past(rst_n)) |-> s2_v_r)
  `SHARP_ASSERT(a_cfg_clears_win, ($past(cfg_we) && $past(rst_n)) |-> (win1 == '0))

endmodule
